### src/ate_pkg.sv
// Shared types and constants of the affine transform engine.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package ate_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned FracBits = 12;
  localparam int unsigned PairW    = 64;
  localparam int unsigned NumPairs = 6;
  localparam int unsigned CfgIdxW  = 3;
  // Only bits FracBits .. FracBits+CoordW-1 of the product sum reach the result.
  localparam int unsigned ProdW    = FracBits + CoordW;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = 2;
  localparam int unsigned QCntW    = 3;

  localparam logic [CfgIdxW-1:0] NumPairsIdx = CfgIdxW'(NumPairs);

  typedef logic [NumPairs-1:0][PairW-1:0] coef_pairs_t;

  // Identity matrix with zero translation: 1.0 is 4096 in 20.12.
  localparam coef_pairs_t CoefPairReset = {
    64'd0, 64'd4096, 64'd0, 64'd4096, 64'd0, 64'd4096
  };

  // Matrix entries indexed [row][col]; row 3 is the translation.
  typedef logic [3:0][2:0][CoordW-1:0] coef_mat_t;

  typedef enum logic [0:0] {
    CmdPoint     = 1'b0,
    CmdDirection = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } item_t;

endpackage

### src/ate_front.sv
// Front end: registers an incoming transaction, decodes its command and
// hands it to the queue. Depends on ate_pkg.
`timescale 1ns / 1ps

module ate_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              command_i,
  input  logic signed [ate_pkg::CoordW-1:0] vec_x_i,
  input  logic signed [ate_pkg::CoordW-1:0] vec_y_i,
  input  logic signed [ate_pkg::CoordW-1:0] vec_z_i,
  input  logic                              q_full_i,
  output logic                              q_push_o,
  output ate_pkg::item_t                    q_item_o
);

  logic           valid_q, valid_d;
  ate_pkg::item_t item_q;
  logic           accept;

  assign in_stall_o = valid_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign q_push_o   = valid_q && !q_full_i;
  assign q_item_o   = item_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (q_push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.cmd <= command_i ? ate_pkg::CmdDirection : ate_pkg::CmdPoint;
      item_q.x   <= vec_x_i;
      item_q.y   <= vec_y_i;
      item_q.z   <= vec_z_i;
    end
  end

endmodule

### src/ate_queue.sv
// Short queue of decoded transactions between the front and back ends.
// Depends on ate_pkg for the item type and the depth constants.
`timescale 1ns / 1ps

module ate_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ate_pkg::item_t push_item_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output ate_pkg::item_t pop_item_o
);

  ate_pkg::item_t                mem_q [ate_pkg::QDepth];
  logic [ate_pkg::QPtrW-1:0]     wptr_q, wptr_d;
  logic [ate_pkg::QPtrW-1:0]     rptr_q, rptr_d;
  logic [ate_pkg::QCntW-1:0]     cnt_q, cnt_d;
  logic                          do_push, do_pop;

  assign full_o     = (cnt_q == ate_pkg::QCntW'(ate_pkg::QDepth));
  assign valid_o    = (cnt_q != '0);
  assign pop_item_o = mem_q[rptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wptr_d = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

endmodule

### src/ate_back.sv
// Back end: nine products in one stage, then sum, scale and translation
// into the output register. Depends on ate_pkg.
`timescale 1ns / 1ps

module ate_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ate_pkg::coef_mat_t                 coef_i,
  input  logic                               q_valid_i,
  input  ate_pkg::item_t                     q_item_i,
  output logic                               q_pop_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [ate_pkg::CoordW-1:0]  out_x_o,
  output logic signed [ate_pkg::CoordW-1:0]  out_y_o,
  output logic signed [ate_pkg::CoordW-1:0]  out_z_o
);

  // Product stage, indexed [col][row].
  logic                                       mul_valid_q;
  ate_pkg::cmd_e                              mul_cmd_q;
  logic [2:0][2:0][ate_pkg::ProdW-1:0]        prod_q, prod_d;
  logic                                       mul_ld;

  logic                                       res_valid_q;
  logic [2:0][ate_pkg::CoordW-1:0]            res_q, res_d;
  logic                                       res_ld;

  assign res_ld  = !res_valid_q || !out_stall_i;
  assign mul_ld  = !mul_valid_q || res_ld;
  assign q_pop_o = q_valid_i && mul_ld;

  always_comb begin
    logic signed [ate_pkg::CoordW-1:0]   vin [3];
    logic signed [2*ate_pkg::CoordW-1:0] full;
    vin[0] = q_item_i.x;
    vin[1] = q_item_i.y;
    vin[2] = q_item_i.z;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        full = vin[r] * $signed(coef_i[r][c]);
        prod_d[c][r] = full[ate_pkg::ProdW-1:0];
      end
    end
  end

  always_comb begin
    logic [ate_pkg::ProdW-1:0]  sum;
    logic [ate_pkg::CoordW-1:0] tr;
    for (int c = 0; c < 3; c++) begin
      // The wrap of the sum never disturbs the bits kept after the shift.
      sum = prod_q[c][0] + prod_q[c][1] + prod_q[c][2];
      tr  = (mul_cmd_q == ate_pkg::CmdPoint) ? coef_i[3][c] : '0;
      res_d[c] = sum[ate_pkg::ProdW-1:ate_pkg::FracBits] + tr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (mul_ld) begin
        mul_valid_q <= q_valid_i;
      end
      if (res_ld) begin
        res_valid_q <= mul_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      mul_cmd_q <= q_item_i.cmd;
      prod_q    <= prod_d;
    end
    if (res_ld && mul_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_x_o     = res_q[0];
  assign out_y_o     = res_q[1];
  assign out_z_o     = res_q[2];

endmodule

### src/affine_transform_engine_unit.sv
// Top level of the affine transform engine: coefficient registers, front end,
// queue and back end. Depends on ate_pkg, ate_front, ate_queue and ate_back.
`timescale 1ns / 1ps

// Transforms a stream of 20.12 vectors by a 4x3 affine matrix held in six
// 64-bit coefficient registers (identity after reset). One transaction is
// accepted per clock cycle while in_stall_o is low, and one result leaves per
// cycle while out_stall_i is low. Each passes the input register, the queue,
// the multiplier stage with its nine 32x32 products, and the sum, scale and
// translation stage that loads the output register. The four-entry queue lets
// the input side keep taking transactions while the output is stalled, until
// it fills. Coefficient writes are always ready and must only be made while
// the block is idle; writes to an index beyond the sixth register are ignored.
module affine_transform_engine_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ate_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [ate_pkg::PairW-1:0]          cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               command_i,
  input  logic signed [ate_pkg::CoordW-1:0]  vec_x_i,
  input  logic signed [ate_pkg::CoordW-1:0]  vec_y_i,
  input  logic signed [ate_pkg::CoordW-1:0]  vec_z_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [ate_pkg::CoordW-1:0]  out_x_o,
  output logic signed [ate_pkg::CoordW-1:0]  out_y_o,
  output logic signed [ate_pkg::CoordW-1:0]  out_z_o
);

  ate_pkg::coef_pairs_t pair_q;
  ate_pkg::coef_mat_t   coef;
  logic                 q_push, q_full, q_valid, q_pop;
  ate_pkg::item_t       q_in_item, q_out_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_q <= ate_pkg::CoefPairReset;
    end else if (cfg_valid_i && cfg_index_i < ate_pkg::NumPairsIdx) begin
      for (int i = 0; i < ate_pkg::NumPairs; i++) begin
        if (cfg_index_i == ate_pkg::CfgIdxW'(i)) begin
          pair_q[i] <= cfg_data_i;
        end
      end
    end
  end

  // Entry (row, col) is number row*3+col; two entries per register, low first.
  always_comb begin
    int k;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        k = r * 3 + c;
        coef[r][c] = pair_q[k >> 1][(k & 1) * ate_pkg::CoordW +: ate_pkg::CoordW];
      end
    end
  end

  ate_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .vec_x_i    (vec_x_i),
    .vec_y_i    (vec_y_i),
    .vec_z_i    (vec_z_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (q_in_item)
  );

  ate_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (q_in_item),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .pop_item_o  (q_out_item)
  );

  ate_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coef_i      (coef),
    .q_valid_i   (q_valid),
    .q_item_i    (q_out_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o)
  );

endmodule

### sim/testbench.sv
// Self-checking testbench for affine_transform_engine_unit.
// Predicts every output vector from its own copy of the coefficient registers
// and compares in order; depends only on ate_pkg and the block itself.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned W = ate_pkg::CoordW;
  localparam int unsigned TxnLimitNs = 5_000_000;

  // Index 0 is x, 1 is y, 2 is z.
  typedef logic [2:0][W-1:0] coord3_t;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              cfg_valid_i;
  logic                              cfg_ready_o;
  logic [ate_pkg::CfgIdxW-1:0]       cfg_index_i;
  logic [ate_pkg::PairW-1:0]         cfg_data_i;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic                              command_i;
  logic signed [W-1:0]               vec_x_i;
  logic signed [W-1:0]               vec_y_i;
  logic signed [W-1:0]               vec_z_i;
  logic                              out_valid_o;
  logic                              out_stall_i;
  logic signed [W-1:0]               out_x_o;
  logic signed [W-1:0]               out_y_o;
  logic signed [W-1:0]               out_z_o;

  logic [ate_pkg::PairW-1:0] coef_model [ate_pkg::NumPairs];
  coord3_t                   expected_vectors [$];
  int unsigned               mismatch_count;
  bit                        sender_idle_en;
  bit                        receiver_idle_en;
  int                        receiver_hold;

  affine_transform_engine_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .vec_x_i     (vec_x_i),
    .vec_y_i     (vec_y_i),
    .vec_z_i     (vec_z_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic logic [W-1:0] coef_entry(int unsigned row, int unsigned col);
    int unsigned             k;
    logic [ate_pkg::PairW-1:0] pair;
    k    = row * 3 + col;
    pair = coef_model[k / 2];
    return (k % 2) ? pair[63:32] : pair[31:0];
  endfunction

  // The low 64 bits of an unsigned product of sign-extended operands equal the
  // signed product modulo 2^64, so the bits kept from the sum match the hardware.
  function automatic coord3_t transform_vector(ate_pkg::cmd_e cmd, coord3_t v);
    coord3_t     res;
    logic [63:0] sum;
    logic [W-1:0] m;
    for (int j = 0; j < 3; j++) begin
      sum = '0;
      for (int r = 0; r < 3; r++) begin
        m    = coef_entry(r, j);
        sum += {{32{v[r][W-1]}}, v[r]} * {{32{m[W-1]}}, m};
      end
      res[j] = sum[ate_pkg::FracBits +: W];
      if (cmd == ate_pkg::CmdPoint) begin
        res[j] += coef_entry(3, j);
      end
    end
    return res;
  endfunction

  function automatic logic [W-1:0] random_coord();
    logic [W-1:0] c;
    case ($urandom_range(0, 3))
      0, 1: c = $urandom;
      // Values within +/-1024.0 keep sums away from wrapping.
      2: c = $urandom_range(0, 2 * 4194304) - 4194304;
      default: begin
        case ($urandom_range(0, 3))
          0: c = 32'h8000_0000;
          1: c = 32'h7FFF_FFFF;
          2: c = 32'hFFFF_FFFF;
          default: c = 32'h0000_0000;
        endcase
      end
    endcase
    return c;
  endfunction

  // Leaves in_valid_i high on return so a following transaction can go out
  // on the very next edge.
  task automatic send_vector(ate_pkg::cmd_e cmd, logic [W-1:0] x, logic [W-1:0] y,
                             logic [W-1:0] z);
    if (sender_idle_en && $urandom_range(0, 99) < 10) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    vec_x_i    <= x;
    vec_y_i    <= y;
    vec_z_i    <= z;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_vectors.push_back(transform_vector(cmd, {z, y, x}));
  endtask

  task automatic wait_for_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_vectors.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_coef(logic [ate_pkg::CfgIdxW-1:0] idx, logic [ate_pkg::PairW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx < ate_pkg::NumPairsIdx) begin
      coef_model[idx] = data;
    end
    @(posedge clk_i);
  endtask

  task automatic test_identity_after_reset();
    send_vector(ate_pkg::CmdPoint, 32'd0, 32'd0, 32'd0);
    send_vector(ate_pkg::CmdPoint, 32'd4096, -32'sd4096, 32'd1);
    send_vector(ate_pkg::CmdDirection, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vector(ate_pkg::CmdDirection, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vector(ate_pkg::CmdPoint, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
    send_vector(ate_pkg::CmdPoint, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_vector(ate_pkg::CmdDirection, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
    send_vector(ate_pkg::CmdPoint, 32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0);
    wait_for_idle();
  endtask

  task automatic test_register_writes();
    // A distinct value per register, so a swapped entry shows up.
    write_coef(3'd0, 64'h0000_1000_0000_2000);
    write_coef(3'd1, 64'hFFFF_F000_0000_0800);
    write_coef(3'd2, 64'h0000_3000_FFFF_E000);
    write_coef(3'd3, 64'h0000_0400_0000_0C00);
    write_coef(3'd4, 64'h0001_0000_FFFF_8000);
    write_coef(3'd5, 64'h8000_0000_7FFF_FFFF);
    // Indexes beyond the last register must leave the matrix alone.
    write_coef(3'd6, 64'hDEAD_BEEF_DEAD_BEEF);
    write_coef(3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
    send_vector(ate_pkg::CmdPoint, 32'd4096, 32'd8192, -32'sd12288);
    send_vector(ate_pkg::CmdDirection, 32'd4096, 32'd8192, -32'sd12288);
    send_vector(ate_pkg::CmdPoint, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
    wait_for_idle();

    for (int i = 0; i < ate_pkg::NumPairs; i++) begin
      write_coef(ate_pkg::CfgIdxW'(i), 64'hFFFF_FFFF_FFFF_FFFF);
    end
    send_vector(ate_pkg::CmdPoint, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vector(ate_pkg::CmdDirection, 32'h7FFF_FFFF, 32'h0000_1000, 32'hFFFF_FFFF);
    wait_for_idle();

    // Three products of 2^62 overflow the 64-bit sum.
    for (int i = 0; i < ate_pkg::NumPairs; i++) begin
      write_coef(ate_pkg::CfgIdxW'(i), 64'h8000_0000_8000_0000);
    end
    send_vector(ate_pkg::CmdPoint, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vector(ate_pkg::CmdDirection, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    wait_for_idle();

    for (int i = 0; i < ate_pkg::NumPairs; i++) begin
      write_coef(ate_pkg::CfgIdxW'(i), 64'h7FFF_FFFF_7FFF_FFFF);
    end
    send_vector(ate_pkg::CmdPoint, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vector(ate_pkg::CmdPoint, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    wait_for_idle();
  endtask

  task automatic test_random_stream();
    logic [W-1:0] lo;
    logic [W-1:0] hi;
    for (int phase = 0; phase < 8; phase++) begin
      // Phase 3 runs with no idling on either side.
      sender_idle_en   = (phase != 3);
      receiver_idle_en = (phase != 3);
      for (int i = 0; i < ate_pkg::NumPairs; i++) begin
        // Even phases use coefficients within +/-4.0, odd ones any pattern.
        lo = (phase % 2 == 0) ? 32'($urandom_range(0, 32768)) - 32'd16384 : random_coord();
        hi = (phase % 2 == 0) ? 32'($urandom_range(0, 32768)) - 32'd16384 : random_coord();
        write_coef(ate_pkg::CfgIdxW'(i), {hi, lo});
      end
      if ($urandom_range(0, 1)) begin
        write_coef(ate_pkg::CfgIdxW'($urandom_range(6, 7)), {$urandom, $urandom});
      end
      for (int n = 0; n < 110; n++) begin
        send_vector(ate_pkg::cmd_e'($urandom_range(0, 1)), random_coord(), random_coord(),
                    random_coord());
      end
      wait_for_idle();
    end
    sender_idle_en   = 1'b1;
    receiver_idle_en = 1'b1;
  endtask

  task automatic test_output_backpressure();
    // The receiver holds off long enough for the queue to fill and the
    // input side to stall while transactions keep being offered.
    receiver_hold = 200;
    for (int n = 0; n < 40; n++) begin
      send_vector(ate_pkg::cmd_e'($urandom_range(0, 1)), random_coord(), random_coord(),
                  random_coord());
    end
    wait_for_idle();
  endtask

  // Result checker and output stall generator.
  initial begin
    coord3_t      want;
    coord3_t      got;
    string        field_name [3];
    field_name[0] = "out_x";
    field_name[1] = "out_y";
    field_name[2] = "out_z";
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got = {out_z_o, out_y_o, out_x_o};
        if (expected_vectors.size() == 0) begin
          $display("%0t: unexpected result x=%h y=%h z=%h", $realtime, got[0], got[1], got[2]);
          mismatch_count++;
        end else begin
          want = expected_vectors.pop_front();
          for (int f = 0; f < 3; f++) begin
            if (got[f] !== want[f]) begin
              $display("%0t: %s expected %h actual %h", $realtime, field_name[f], want[f],
                       got[f]);
              mismatch_count++;
            end
          end
        end
      end
      if (receiver_hold > 0) begin
        out_stall_i <= 1'b1;
        receiver_hold--;
      end else begin
        out_stall_i <= receiver_idle_en && ($urandom_range(0, 99) < 10);
      end
    end
  end

  initial begin
    #(TxnLimitNs);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    mismatch_count   = 0;
    sender_idle_en   = 1'b1;
    receiver_idle_en = 1'b1;
    receiver_hold    = 0;
    for (int i = 0; i < ate_pkg::NumPairs; i++) coef_model[i] = ate_pkg::CoefPairReset[i];
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    command_i   <= 1'b0;
    vec_x_i     <= '0;
    vec_y_i     <= '0;
    vec_z_i     <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_identity_after_reset();
    test_register_writes();
    test_random_stream();
    test_output_backpressure();

    if (mismatch_count == 0 && expected_vectors.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
